### src/saik_pkg.sv
package saik_pkg;

   localparam int GUARD_BITS = 8;
   localparam int VW = 45;
   localparam int AW = 32;
   localparam logic signed [AW-1:0] PI_Q28 = 32'sd843314857;
   localparam logic signed [AW-1:0] HALF_PI_Q28 = 32'sd421657428;
   localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

   localparam logic [2:0] CSR_BASE_X = 3'd0;
   localparam logic [2:0] CSR_BASE_Y = 3'd1;
   localparam logic [2:0] CSR_BASE_Z = 3'd2;
   localparam logic [2:0] CSR_SHOULDER = 3'd3;
   localparam logic [2:0] CSR_REACH = 3'd4;

   typedef logic signed [VW-1:0] vec_type;
   typedef logic signed [AW-1:0] ang_type;

   typedef struct packed {
      vec_type x;
      vec_type y;
      ang_type z;
      logic zero;
   } cordic_type;

   function automatic ang_type atan_q28(input int i);
      unique case (i)
         0: atan_q28 = 32'sd210828714;
         1: atan_q28 = 32'sd124459457;
         2: atan_q28 = 32'sd65760959;
         3: atan_q28 = 32'sd33381290;
         4: atan_q28 = 32'sd16755422;
         5: atan_q28 = 32'sd8385879;
         6: atan_q28 = 32'sd4193963;
         7: atan_q28 = 32'sd2097109;
         8: atan_q28 = 32'sd1048571;
         9: atan_q28 = 32'sd524287;
         10: atan_q28 = 32'sd262144;
         11: atan_q28 = 32'sd131072;
         12: atan_q28 = 32'sd65536;
         13: atan_q28 = 32'sd32768;
         14: atan_q28 = 32'sd16384;
         15: atan_q28 = 32'sd8192;
         16: atan_q28 = 32'sd4096;
         17: atan_q28 = 32'sd2048;
         18: atan_q28 = 32'sd1024;
         19: atan_q28 = 32'sd512;
         20: atan_q28 = 32'sd256;
         21: atan_q28 = 32'sd128;
         22: atan_q28 = 32'sd64;
         23: atan_q28 = 32'sd32;
         24: atan_q28 = 32'sd16;
         25: atan_q28 = 32'sd8;
         26: atan_q28 = 32'sd4;
         27: atan_q28 = 32'sd2;
         28: atan_q28 = 32'sd1;
         default: atan_q28 = '0;
      endcase
   endfunction

endpackage

### src/saik_cordic.sv
module saik_cordic #(
   parameter int STAGES = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  saik_pkg::cordic_type in_data,
   output logic out_valid,
   output saik_pkg::cordic_type out_data
);
   import saik_pkg::*;

   cordic_type stage_d [STAGES+1];
   logic [STAGES:0] valid_d;

   assign stage_d[0] = in_data;
   assign valid_d[0] = in_valid;

   genvar i;
   generate
      for (i = 0; i < STAGES; i++) begin : g_stage
         cordic_type st_in;
         logic v_ff;
         cordic_type d_ff;
         always_comb begin
            st_in = stage_d[i];
            if (stage_d[i].y >= 0) begin
               st_in.x = stage_d[i].x + (stage_d[i].y >>> i);
               st_in.y = stage_d[i].y - (stage_d[i].x >>> i);
               st_in.z = stage_d[i].z + atan_q28(i);
            end else begin
               st_in.x = stage_d[i].x - (stage_d[i].y >>> i);
               st_in.y = stage_d[i].y + (stage_d[i].x >>> i);
               st_in.z = stage_d[i].z - atan_q28(i);
            end
         end
         always_ff @(posedge clock) begin
            if (reset) v_ff <= 1'b0;
            else v_ff <= valid_d[i];
            d_ff <= st_in;
         end
         assign stage_d[i+1] = d_ff;
         assign valid_d[i+1] = v_ff;
      end
   endgenerate

   assign out_valid = valid_d[STAGES];
   assign out_data = stage_d[STAGES];
endmodule

### src/saik_gain.sv
module saik_gain (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  saik_pkg::vec_type in_x,
   input  logic in_zero,
   output logic out_valid,
   output saik_pkg::vec_type out_mag
);
   import saik_pkg::*;

   logic [47:0] u;
   logic [31:0] hi_ff;
   logic [15:0] lo_ff;
   logic v1_ff, v2_ff;
   logic [61:0] ph_ff;
   logic [45:0] pl_ff;
   logic [62:0] sum;

   assign u = (in_zero || in_x < 0) ? 48'd0 : 48'(in_x);
   assign sum = 63'(ph_ff) + 63'(pl_ff >> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      hi_ff <= u[47:16];
      lo_ff <= u[15:0];
      ph_ff <= 62'(hi_ff) * 62'(INV_GAIN_Q30);
      pl_ff <= 46'(lo_ff) * 46'(INV_GAIN_Q30);
   end

   assign out_valid = v2_ff;
   assign out_mag = VW'(sum >> 14);
endmodule

### src/spherical_arm_inverse_kinematics_core.sv
// One target per cycle in, one result per target out, in order, rsp_valid
// high for exactly one cycle; the receiver cannot stall. rsp_valid passes
// through 2*CORDIC_STAGES+7 register stages: front register, two CORDIC
// vectoring pipelines of CORDIC_STAGES stages, each followed by a two-stage
// gain multiplier, a queue stage between passes and an output register.
module spherical_arm_inverse_kinematics_core #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_wdata,
   output logic rsp_valid,
   output logic signed [30:0] rsp_base_angle,
   output logic signed [29:0] rsp_elevation_angle,
   output logic signed [31:0] rsp_reach_extension,
   output logic rsp_reach_saturated
);
   import saik_pkg::*;

   localparam int LAT1 = CORDIC_STAGES + 2;

   logic signed [31:0] base_x_ff, base_y_ff, base_z_ff;
   logic [30:0] shoulder_ff, reach_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff <= '0;
         base_y_ff <= '0;
         base_z_ff <= '0;
         shoulder_ff <= '0;
         reach_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_X: base_x_ff <= csr_wdata;
            CSR_BASE_Y: base_y_ff <= csr_wdata;
            CSR_BASE_Z: base_z_ff <= csr_wdata;
            CSR_SHOULDER: shoulder_ff <= csr_wdata[30:0];
            CSR_REACH: reach_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // front: differences and quadrant
   logic signed [33:0] dx, dy, s;
   cordic_type p1_in, p1_ff;
   logic f_v_ff;
   logic signed [VW-1:0] s_ff;

   always_comb begin
      dx = 34'(req_target_x) - 34'(base_x_ff);
      dy = 34'(req_target_y) - 34'(base_y_ff);
      s = 34'(req_target_z) - 34'(base_z_ff) - 34'({1'b0, shoulder_ff});
      p1_in.zero = (dx == 0) && (dy == 0);
      p1_in.z = '0;
      p1_in.x = VW'(dx) <<< GUARD_BITS;
      p1_in.y = VW'(dy) <<< GUARD_BITS;
      if (dx < 0) begin
         if (dy >= 0) begin
            p1_in.x = VW'(dy) <<< GUARD_BITS;
            p1_in.y = -(VW'(dx) <<< GUARD_BITS);
            p1_in.z = HALF_PI_Q28;
         end else begin
            p1_in.x = -(VW'(dy) <<< GUARD_BITS);
            p1_in.y = VW'(dx) <<< GUARD_BITS;
            p1_in.z = -HALF_PI_Q28;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) f_v_ff <= 1'b0;
      else f_v_ff <= start;
      p1_ff <= p1_in;
      s_ff <= VW'(s) <<< GUARD_BITS;
   end

   // s travels alongside pass one
   vec_type s_dly_ff [LAT1];
   always_ff @(posedge clock) begin
      s_dly_ff[0] <= s_ff;
      for (int k = 1; k < LAT1; k++) s_dly_ff[k] <= s_dly_ff[k-1];
   end

   logic c1_v;
   cordic_type c1_d;
   saik_cordic #(.STAGES(CORDIC_STAGES)) u_pass1 (
      .clock(clock), .reset(reset), .in_valid(f_v_ff), .in_data(p1_ff),
      .out_valid(c1_v), .out_data(c1_d));

   logic g1_v;
   vec_type r;
   ang_type a1_raw_ff [2];
   logic z1_ff [2];
   saik_gain u_gain1 (
      .clock(clock), .reset(reset), .in_valid(c1_v), .in_x(c1_d.x),
      .in_zero(c1_d.zero), .out_valid(g1_v), .out_mag(r));

   always_ff @(posedge clock) begin
      a1_raw_ff[0] <= c1_d.z;
      a1_raw_ff[1] <= a1_raw_ff[0];
      z1_ff[0] <= c1_d.zero;
      z1_ff[1] <= z1_ff[0];
   end

   // queue stage between passes
   cordic_type p2_ff;
   logic q_v_ff;
   ang_type a1_ff;
   always_ff @(posedge clock) begin
      if (reset) q_v_ff <= 1'b0;
      else q_v_ff <= g1_v;
      p2_ff.x <= r;
      p2_ff.y <= s_dly_ff[LAT1-1];
      p2_ff.z <= '0;
      p2_ff.zero <= (r == 0) && (s_dly_ff[LAT1-1] == 0);
      if (z1_ff[1]) a1_ff <= '0;
      else if (a1_raw_ff[1] > PI_Q28) a1_ff <= PI_Q28;
      else if (a1_raw_ff[1] < -PI_Q28) a1_ff <= -PI_Q28;
      else a1_ff <= a1_raw_ff[1];
   end

   ang_type a1_dly_ff [LAT1];
   always_ff @(posedge clock) begin
      a1_dly_ff[0] <= a1_ff;
      for (int k = 1; k < LAT1; k++) a1_dly_ff[k] <= a1_dly_ff[k-1];
   end

   logic c2_v;
   cordic_type c2_d;
   saik_cordic #(.STAGES(CORDIC_STAGES)) u_pass2 (
      .clock(clock), .reset(reset), .in_valid(q_v_ff), .in_data(p2_ff),
      .out_valid(c2_v), .out_data(c2_d));

   logic g2_v;
   vec_type dmag;
   ang_type a2_raw_ff [2];
   logic z2_ff [2];
   saik_gain u_gain2 (
      .clock(clock), .reset(reset), .in_valid(c2_v), .in_x(c2_d.x),
      .in_zero(c2_d.zero), .out_valid(g2_v), .out_mag(dmag));

   always_ff @(posedge clock) begin
      a2_raw_ff[0] <= c2_d.z;
      a2_raw_ff[1] <= a2_raw_ff[0];
      z2_ff[0] <= c2_d.zero;
      z2_ff[1] <= z2_ff[0];
   end

   // output register
   logic signed [VW-1:0] reach;
   ang_type a2;
   logic o_v_ff;
   logic signed [30:0] o_a1_ff;
   logic signed [29:0] o_a2_ff;
   logic signed [31:0] o_r_ff;
   logic o_s_ff;

   always_comb begin
      reach = (dmag >>> GUARD_BITS) - VW'({1'b0, reach_ff});
      if (z2_ff[1]) a2 = '0;
      else if (a2_raw_ff[1] > HALF_PI_Q28) a2 = HALF_PI_Q28;
      else if (a2_raw_ff[1] < -HALF_PI_Q28) a2 = -HALF_PI_Q28;
      else a2 = a2_raw_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else o_v_ff <= g2_v;
      o_a1_ff <= a1_dly_ff[LAT1-1][30:0];
      o_a2_ff <= a2[29:0];
      if (reach > VW'(32'sh7FFFFFFF)) begin
         o_r_ff <= 32'sh7FFFFFFF;
         o_s_ff <= 1'b1;
      end else if (reach < -VW'(33'sh080000000)) begin
         o_r_ff <= 32'sh80000000;
         o_s_ff <= 1'b1;
      end else begin
         o_r_ff <= reach[31:0];
         o_s_ff <= 1'b0;
      end
   end

   assign rsp_valid = o_v_ff;
   assign rsp_base_angle = o_a1_ff;
   assign rsp_elevation_angle = o_a2_ff;
   assign rsp_reach_extension = o_r_ff;
   assign rsp_reach_saturated = o_s_ff;
endmodule

### src/saik_checker.sv
module saik_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic signed [30:0] rsp_base_angle,
   input logic signed [29:0] rsp_elevation_angle,
   input logic rsp_reach_saturated,
   input logic signed [31:0] rsp_reach_extension
);
   a_busy: assert property (@(posedge clock) !busy) else $error("busy raised");
   a_ang: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_base_angle <= 31'sd843314857 &&
                     rsp_base_angle >= -31'sd843314857)) else $error("angle range");
   a_el: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_elevation_angle <= 30'sd421657428 &&
                     rsp_elevation_angle >= -30'sd421657428)) else $error("elev range");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reach_saturated) |->
      (rsp_reach_extension == 32'sh7FFFFFFF || rsp_reach_extension == 32'sh80000000))
      else $error("sat value");
endmodule

bind spherical_arm_inverse_kinematics_core saik_checker u_saik_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_base_angle(rsp_base_angle),
   .rsp_elevation_angle(rsp_elevation_angle),
   .rsp_reach_saturated(rsp_reach_saturated),
   .rsp_reach_extension(rsp_reach_extension));

### tb/spherical_arm_inverse_kinematics_core_test.sv
module spherical_arm_inverse_kinematics_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import saik_pkg::*;

   localparam int STAGES = 24;
   localparam int LATENCY = 2 * STAGES + 9;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM = 1700;

   typedef struct {
      logic signed [30:0] base_angle;
      logic signed [29:0] elevation_angle;
      logic signed [31:0] reach_extension;
      logic reach_saturated;
   } joints_type;

   longint arm_base_x, arm_base_y, arm_base_z, arm_shoulder, arm_reach;
   int error_count;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic longint shr_floor(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint remove_gain(input longint v);
      longint unsigned u, p;
      u = v;
      p = (u >> 16) * 64'd652032874 + (((u & 64'hFFFF) * 64'd652032874) >> 16);
      return longint'(p >> 14);
   endfunction

   function automatic longint vector_angle(input longint xi, input longint yi,
                                           output longint mag);
      longint x, y, z, xs, ys;
      x = xi; y = yi; z = 0;
      for (int i = 0; i < STAGES && i < 32; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (y >= 0) begin
            x = x + ys; y = y - xs; z += longint'(atan_q28(i));
         end else begin
            x = x - ys; y = y + xs; z -= longint'(atan_q28(i));
         end
      end
      mag = remove_gain(x < 0 ? 0 : x);
      return z;
   endfunction

   function automatic longint clip(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic joints_type solve_joints(input logic signed [31:0] tx,
         input logic signed [31:0] ty, input logic signed [31:0] tz);
      joints_type j;
      longint dx, dy, s, a1, a2, r, d, reach, x, y, pre;
      dx = (longint'(tx) - arm_base_x) * 256;
      dy = (longint'(ty) - arm_base_y) * 256;
      s = (longint'(tz) - arm_base_z - arm_shoulder) * 256;
      a1 = 0; a2 = 0; r = 0; d = 0;
      if (dx != 0 || dy != 0) begin
         x = dx; y = dy; pre = 0;
         if (x < 0) begin
            if (y >= 0) begin
               x = dy; y = -dx; pre = 421657428;
            end else begin
               x = -dy; y = dx; pre = -421657428;
            end
         end
         a1 = clip(pre + vector_angle(x, y, r), 843314857);
      end
      if (r != 0 || s != 0) a2 = clip(vector_angle(r, s, d), 421657428);
      reach = shr_floor(d, 8) - arm_reach;
      j.reach_saturated = 0;
      if (reach > 64'sd2147483647) begin
         reach = 64'sd2147483647; j.reach_saturated = 1;
      end
      if (reach < -64'sd2147483648) begin
         reach = -64'sd2147483648; j.reach_saturated = 1;
      end
      j.base_angle = a1[30:0];
      j.elevation_angle = a2[29:0];
      j.reach_extension = reach[31:0];
      return j;
   endfunction

   class joint_scoreboard;
      joints_type pending[$];
      function void note_target(input logic signed [31:0] tx, input logic signed [31:0] ty,
                                input logic signed [31:0] tz);
         pending.insert(pending.size(), solve_joints(tx, ty, tz));
      endfunction
      task check_result(input joints_type got);
         joints_type w;
         if (pending.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
            return;
         end
         w = pending.pop_front();
         if (got.base_angle !== w.base_angle)
            report_mismatch("base_angle", got.base_angle, w.base_angle);
         if (got.elevation_angle !== w.elevation_angle)
            report_mismatch("elevation_angle", got.elevation_angle, w.elevation_angle);
         if (got.reach_extension !== w.reach_extension)
            report_mismatch("reach_extension", got.reach_extension, w.reach_extension);
         if (got.reach_saturated !== w.reach_saturated)
            report_mismatch("reach_saturated", got.reach_saturated, w.reach_saturated);
      endtask
   endclass

   logic clock, reset, start, busy, csr_we, rsp_valid, rsp_reach_saturated;
   logic signed [31:0] req_target_x, req_target_y, req_target_z, rsp_reach_extension;
   logic [2:0] csr_index;
   logic [31:0] csr_wdata;
   logic signed [30:0] rsp_base_angle;
   logic signed [29:0] rsp_elevation_angle;
   int idle_cycles;
   joint_scoreboard joints_sb;

   spherical_arm_inverse_kinematics_core #(.CORDIC_STAGES(STAGES)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .req_target_z(req_target_z), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .rsp_valid(rsp_valid), .rsp_base_angle(rsp_base_angle),
      .rsp_elevation_angle(rsp_elevation_angle),
      .rsp_reach_extension(rsp_reach_extension),
      .rsp_reach_saturated(rsp_reach_saturated)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      joints_type got;
      if (!reset) begin
         if (rsp_valid) begin
            got.base_angle = rsp_base_angle;
            got.elevation_angle = rsp_elevation_angle;
            got.reach_extension = rsp_reach_extension;
            got.reach_saturated = rsp_reach_saturated;
            joints_sb.check_result(got);
         end
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         CSR_BASE_X: arm_base_x = longint'(signed'(val));
         CSR_BASE_Y: arm_base_y = longint'(signed'(val));
         CSR_BASE_Z: arm_base_z = longint'(signed'(val));
         CSR_SHOULDER: arm_shoulder = longint'(val[30:0]);
         CSR_REACH: arm_reach = longint'(val[30:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (joints_sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_target(input logic [31:0] tx, input logic [31:0] ty,
                              input logic [31:0] tz, input bit keep);
      start <= 1; req_target_x <= tx; req_target_y <= ty; req_target_z <= tz;
      @(posedge clock);
      while (busy) @(posedge clock);
      joints_sb.note_target(tx, ty, tz);
      if (!keep) begin
         start <= 0;
         @(posedge clock);
      end
   endtask

   task automatic random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return;
      if (r < 95) repeat ($urandom_range(1, 3)) @(posedge clock);
      else repeat ($urandom_range(10, 80)) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'(signed'($urandom_range(0, 16)) - 8);
         3, 4: return 32'(signed'($urandom_range(0, 200000)) - 100000);
         5, 6: return 32'(signed'($urandom_range(0, 40000000)) - 20000000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_reg(input bit unsigned_reg);
      logic [31:0] v;
      case ($urandom_range(0, 4))
         0: v = 0;
         1: v = unsigned_reg ? 32'h7FFFFFFF : 32'h80000000;
         2: v = 32'h7FFFFFFF;
         3: v = 32'(signed'($urandom_range(0, 2000000)) - 1000000);
         default: v = $urandom;
      endcase
      if (unsigned_reg) v[31] = 1'($urandom_range(0, 1));
      return v;
   endfunction

   initial begin
      logic [31:0] dir[12][3];
      bit keep;
      joints_sb = new();
      error_count = 0; idle_cycles = 0;
      arm_base_x = 0; arm_base_y = 0; arm_base_z = 0; arm_shoulder = 0; arm_reach = 0;
      reset = 1; start = 0; csr_we = 0; csr_index = 0; csr_wdata = 0;
      req_target_x = 0; req_target_y = 0; req_target_z = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      dir = '{'{0, 0, 0}, '{0, 0, 32'h10000}, '{0, 0, 32'hFFFF0000},
              '{32'hFFFF0000, 0, 0}, '{32'hFFFF0000, 32'hFFFFFFFF, 5},
              '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF},
              '{32'h80000000, 32'h80000000, 32'h80000000},
              '{32'h80000000, 32'h7FFFFFFF, 0}, '{0, 32'h80000000, 32'h7FFFFFFF},
              '{32'h10000, 32'h10000, 32'h10000}, '{1, 0, 0}, '{0, 1, 32'hFFFFFFFF}};
      foreach (dir[i]) send_target(dir[i][0], dir[i][1], dir[i][2], 0);
      wait_drained();
      write_reg(CSR_BASE_X, 32'h7FFFFFFF);
      write_reg(CSR_BASE_Y, 32'h80000000);
      write_reg(CSR_BASE_Z, 32'h80000000);
      write_reg(CSR_SHOULDER, 32'h7FFFFFFF);
      write_reg(CSR_REACH, 0);
      write_reg(3'd7, $urandom);
      foreach (dir[i]) send_target(dir[i][0], dir[i][1], dir[i][2], 0);
      wait_drained();
      write_reg(CSR_REACH, 32'h7FFFFFFF);
      write_reg(CSR_BASE_X, 32'h80000000);
      write_reg(CSR_BASE_Z, 32'h7FFFFFFF);
      for (int i = 0; i < 6; i++) send_target(dir[i][0], dir[i][1], dir[i][2], 0);
      wait_drained();
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 200 == 0) begin
            wait_drained();
            if (n % 400 == 0) begin
               write_reg(CSR_BASE_X, 0); write_reg(CSR_BASE_Y, 0); write_reg(CSR_BASE_Z, 0);
               write_reg(CSR_SHOULDER, 0); write_reg(CSR_REACH, 0);
            end else begin
               write_reg(CSR_BASE_X, pick_reg(0)); write_reg(CSR_BASE_Y, pick_reg(0));
               write_reg(CSR_BASE_Z, pick_reg(0)); write_reg(CSR_SHOULDER, pick_reg(1));
               write_reg(CSR_REACH, pick_reg(1));
            end
         end
         keep = ($urandom_range(0, 99) < 45) && (n % 200 != 199);
         send_target(pick_coord(), pick_coord(), pick_coord(), keep);
         if (!keep) random_gap();
      end
      start <= 0;
      wait_drained();
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

### filelist.f
src/saik_pkg.sv
src/saik_cordic.sv
src/saik_gain.sv
src/spherical_arm_inverse_kinematics_core.sv
src/saik_checker.sv
tb/spherical_arm_inverse_kinematics_core_test.sv
